### hdl/atomic_memory_with_reservations_defines.svh
// ----------------------------------------------------------------------------
// Atomic memory with reservations: assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ATOMIC_MEMORY_WITH_RESERVATIONS_DEFINES_SVH
`define ATOMIC_MEMORY_WITH_RESERVATIONS_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define AMR_CHECK_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amr checker: property violated");

// Next-cycle implication, clocked on clk, quiet while rst_n is low.
`define AMR_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amr checker: property violated");

`endif

### hdl/amr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_pkg
// Widths, opcodes, shared types and size helpers for the atomic memory.
// ----------------------------------------------------------------------------
package amr_pkg;

    localparam int MEM_BYTES_DEF = 65536;
    localparam int NUM_INIT_DEF  = 16;

    localparam int MODE_W = 4;
    localparam int ADDR_W = 16;
    localparam int CNT_W  = 4;
    localparam int DATA_W = 64;
    localparam int INIT_W = 4;
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    localparam logic [MODE_W-1:0] OP_READ  = 4'd0;
    localparam logic [MODE_W-1:0] OP_WRITE = 4'd1;
    localparam logic [MODE_W-1:0] OP_LR    = 4'd2;
    localparam logic [MODE_W-1:0] OP_SC    = 4'd3;
    localparam logic [MODE_W-1:0] OP_SWAP  = 4'd4;
    localparam logic [MODE_W-1:0] OP_ADD   = 4'd5;
    localparam logic [MODE_W-1:0] OP_XOR   = 4'd6;
    localparam logic [MODE_W-1:0] OP_AND   = 4'd7;
    localparam logic [MODE_W-1:0] OP_OR    = 4'd8;
    localparam logic [MODE_W-1:0] OP_MIN   = 4'd9;
    localparam logic [MODE_W-1:0] OP_MAX   = 4'd10;
    localparam logic [MODE_W-1:0] OP_MINU  = 4'd11;
    localparam logic [MODE_W-1:0] OP_MAXU  = 4'd12;

    // Request seen by the reservation table.
    typedef struct packed {
        logic              lr;
        logic              sc;
        logic [INIT_W-1:0] who;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
    } resv_req_t;

    // Low n bytes set.
    function automatic logic [DATA_W-1:0] size_mask(input logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] m;
        begin
            case (n)
                4'd1:    m = 64'h0000_0000_0000_00FF;
                4'd2:    m = 64'h0000_0000_0000_FFFF;
                4'd3:    m = 64'h0000_0000_00FF_FFFF;
                4'd4:    m = 64'h0000_0000_FFFF_FFFF;
                4'd5:    m = 64'h0000_00FF_FFFF_FFFF;
                4'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
                4'd7:    m = 64'h00FF_FFFF_FFFF_FFFF;
                4'd8:    m = 64'hFFFF_FFFF_FFFF_FFFF;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    // Sign-extend from the top bit of the low n bytes.
    function automatic logic [DATA_W-1:0] sign_ext(input logic [DATA_W-1:0] v,
                                                   input logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] r;
        begin
            case (n)
                4'd1:    r = {{56{v[7]}},  v[7:0]};
                4'd2:    r = {{48{v[15]}}, v[15:0]};
                4'd3:    r = {{40{v[23]}}, v[23:0]};
                4'd4:    r = {{32{v[31]}}, v[31:0]};
                4'd5:    r = {{24{v[39]}}, v[39:0]};
                4'd6:    r = {{16{v[47]}}, v[47:0]};
                4'd7:    r = {{8{v[55]}},  v[55:0]};
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

### hdl/amr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module amr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/amr_resv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_resv
// Per-initiator reservation table for load-reserved / store-conditional.
// ----------------------------------------------------------------------------
module amr_resv #(
    parameter int NUM_INITIATORS = amr_pkg::NUM_INIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  amr_pkg::resv_req_t req,
    output logic               sc_ok
);

    localparam int IDX_W = (NUM_INITIATORS > 1) ? $clog2(NUM_INITIATORS) : 1;

    logic [NUM_INITIATORS-1:0]  resv_valid_reg;
    logic [NUM_INITIATORS-1:0]  resv_valid_next;
    logic [amr_pkg::ADDR_W-1:0] resv_addr_reg [NUM_INITIATORS];

    logic [IDX_W+amr_pkg::INIT_W-1:0] who_w;
    logic [IDX_W-1:0]                 idx;
    logic                             who_ok;
    logic [amr_pkg::ADDR_W:0]         range_end;
    logic [NUM_INITIATORS-1:0]        hit;

    assign who_w     = (IDX_W + amr_pkg::INIT_W)'(req.who);
    assign idx       = who_w[IDX_W-1:0];
    assign who_ok    = 32'(req.who) < NUM_INITIATORS;
    assign range_end = (amr_pkg::ADDR_W + 1)'(req.addr) + (amr_pkg::ADDR_W + 1)'(req.cnt);

    assign sc_ok = who_ok && resv_valid_reg[idx] && (resv_addr_reg[idx] == req.addr);

    // Each entry checks its own address against the SC byte range.
    always_comb
    begin
        for (int k = 0; k < NUM_INITIATORS; k++)
        begin
            hit[k] = resv_valid_reg[k] && (resv_addr_reg[k] >= req.addr) &&
                     ((amr_pkg::ADDR_W + 1)'(resv_addr_reg[k]) < range_end);
        end
    end

    always_comb
    begin
        resv_valid_next = resv_valid_reg;
        if (fire && req.lr && who_ok)
        begin
            resv_valid_next[idx] = 1'b1;
        end
        else if (fire && req.sc && sc_ok)
        begin
            resv_valid_next = resv_valid_reg & ~hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resv_valid_reg <= '0;
        end
        else
        begin
            resv_valid_reg <= resv_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && req.lr && who_ok)
        begin
            resv_addr_reg[idx] <= req.addr;
        end
    end

endmodule

### hdl/amr_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_alu
// Combines the old value and operand per opcode; picks the returned value.
// ----------------------------------------------------------------------------
module amr_alu (
    input  logic [amr_pkg::MODE_W-1:0] mode,
    input  logic [amr_pkg::CNT_W-1:0]  cnt,
    input  logic [amr_pkg::DATA_W-1:0] old_val,
    input  logic [amr_pkg::DATA_W-1:0] opnd,
    input  logic                       sc_ok,
    output logic [amr_pkg::DATA_W-1:0] new_val,
    output logic [amr_pkg::DATA_W-1:0] ret_val,
    output logic                       do_write
);

    logic signed [amr_pkg::DATA_W-1:0] s_old;
    logic signed [amr_pkg::DATA_W-1:0] s_opnd;
    logic [amr_pkg::DATA_W-1:0]        res;

    assign s_old  = $signed(amr_pkg::sign_ext(old_val, cnt));
    assign s_opnd = $signed(amr_pkg::sign_ext(opnd, cnt));

    always_comb
    begin
        res      = '0;
        ret_val  = old_val;
        do_write = 1'b1;
        case (mode)
            amr_pkg::OP_READ:  do_write = 1'b0;
            amr_pkg::OP_WRITE:
            begin
                res     = opnd;
                ret_val = '0;
            end
            amr_pkg::OP_LR:    do_write = 1'b0;
            amr_pkg::OP_SC:
            begin
                if (sc_ok)
                begin
                    res     = opnd;
                    ret_val = '0;
                end
                else
                begin
                    do_write = 1'b0;
                    ret_val  = 64'd1;
                end
            end
            amr_pkg::OP_SWAP:  res = opnd;
            amr_pkg::OP_ADD:   res = old_val + opnd;
            amr_pkg::OP_XOR:   res = old_val ^ opnd;
            amr_pkg::OP_AND:   res = old_val & opnd;
            amr_pkg::OP_OR:    res = old_val | opnd;
            amr_pkg::OP_MIN:   res = (s_old < s_opnd) ? old_val : opnd;
            amr_pkg::OP_MAX:   res = (s_old > s_opnd) ? old_val : opnd;
            amr_pkg::OP_MINU:  res = (old_val < opnd) ? old_val : opnd;
            amr_pkg::OP_MAXU:  res = (old_val > opnd) ? old_val : opnd;
            default:
            begin
                do_write = 1'b0;
                ret_val  = '0;
            end
        endcase
    end

    assign new_val = res & amr_pkg::size_mask(cnt);

endmodule

### hdl/atomic_memory_with_reservations.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atomic_memory_with_reservations
// Byte-addressed memory with reads, writes, AMOs and LR/SC reservations.
// ----------------------------------------------------------------------------
// One access per input word: mode in tuser, address / byte count / write data /
// initiator in tdata. Each accepted word yields exactly one result word: status
// in tuser (1 = invalid access) and read data in tdata, upper bytes zero. The
// accept cycle issues the reads to eight byte-lane RAMs; the execute state then
// combines old data with the operand and writes back through the same RAM
// ports, and no new word is taken until that write-back is done. A full output
// register that is not drained stalls the write-back. Any byte alignment works
// because byte a lives in lane a mod 8, row a / 8; lanes below the start lane
// use the following row. The store needs no clearing after reset, so the block
// accepts words right out of reset. The user writes power_on via cfg_wr_en and
// cfg_wr_data only while no access is in flight; the block does not enforce it.
module atomic_memory_with_reservations #(
    parameter int MEM_BYTES      = amr_pkg::MEM_BYTES_DEF,
    parameter int NUM_INITIATORS = amr_pkg::NUM_INIT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] address, [19:16] byte_count, [83:20] write_data, [87:84] initiator
    input  logic [87:0]  s_axis_tdata,
    // [3:0] mode
    input  logic [3:0]   s_axis_tuser,
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] read_data
    output logic [63:0]  m_axis_tdata,
    // [0] status
    output logic [0:0]   m_axis_tuser,
    // Configuration
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);

    localparam int ROWS  = (MEM_BYTES + 7) / 8;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    // Unpack the input word.
    logic [amr_pkg::MODE_W-1:0] in_mode;
    logic [amr_pkg::ADDR_W-1:0] in_addr;
    logic [amr_pkg::CNT_W-1:0]  in_cnt;
    logic [amr_pkg::DATA_W-1:0] in_wdata;
    logic [amr_pkg::INIT_W-1:0] in_who;

    assign in_mode  = s_axis_tuser;
    assign in_addr  = s_axis_tdata[15:0];
    assign in_cnt   = s_axis_tdata[19:16];
    assign in_wdata = s_axis_tdata[83:20];
    assign in_who   = s_axis_tdata[87:84];

    // Control and request registers.
    logic [0:0]                 state_reg, state_next;
    logic                       power_on_reg, power_on_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_status_reg, out_status_next;
    logic [amr_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic [amr_pkg::MODE_W-1:0] req_mode_reg, req_mode_next;
    logic [amr_pkg::ADDR_W-1:0] req_addr_reg, req_addr_next;
    logic [amr_pkg::CNT_W-1:0]  req_cnt_reg, req_cnt_next;
    logic [amr_pkg::DATA_W-1:0] req_wdata_reg, req_wdata_next;
    logic [amr_pkg::INIT_W-1:0] req_who_reg, req_who_next;

    logic accept;
    logic slot_free;
    logic exec_fire;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign exec_fire     = (state_reg == ST_EXEC) && slot_free;

    // Range and opcode checks on the held request.
    logic       cnt_ok;
    logic       mode_ok;
    logic       range_ok;
    logic       req_ok;

    assign cnt_ok   = req_cnt_reg inside {[4'd1:4'd8]};
    assign mode_ok  = req_mode_reg <= amr_pkg::OP_MAXU;
    assign range_ok = (32'(req_addr_reg) + 32'(req_cnt_reg)) <= 32'(MEM_BYTES);
    assign req_ok   = cnt_ok && mode_ok && range_ok;

    // Byte-lane memory: the address comes from the input while accepting,
    // from the held request while writing back.
    logic [amr_pkg::ADDR_W-1:0] lane_base;
    logic [ROW_W-1:0]           bank_row   [amr_pkg::LANES];
    logic [7:0]                 bank_rd    [amr_pkg::LANES];
    logic [7:0]                 bank_wbyte [amr_pkg::LANES];
    logic                       bank_we    [amr_pkg::LANES];

    assign lane_base = (state_reg == ST_IDLE) ? in_addr : req_addr_reg;

    logic [amr_pkg::DATA_W-1:0] new_val;
    logic [amr_pkg::DATA_W-1:0] ret_val;
    logic                       do_write;
    logic                       wr_en;

    for (genvar j = 0; j < amr_pkg::LANES; j++)
    begin : g_lane
        logic [31:0]                row_sum;
        logic [amr_pkg::LANE_W-1:0] off;

        // Lanes below the start lane hold bytes of the next row.
        assign row_sum = 32'(lane_base) +
                         ((amr_pkg::LANE_W'(j) < lane_base[2:0]) ? 32'd8 : 32'd0);
        assign bank_row[j] = row_sum[ROW_W+2:3];

        // Byte position of this lane inside the access.
        assign off           = amr_pkg::LANE_W'(j) - req_addr_reg[2:0];
        assign bank_wbyte[j] = 8'(new_val >> {off, 3'b000});
        assign bank_we[j]    = wr_en && ({1'b0, off} < req_cnt_reg);

        amr_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[j]),
            .re    (accept),
            .addr  (bank_row[j]),
            .wdata (bank_wbyte[j]),
            .rdata (bank_rd[j])
        );
    end

    // Rotate lane data back into access order.
    logic [amr_pkg::DATA_W-1:0] old_raw;
    logic [amr_pkg::DATA_W-1:0] mask;
    logic [amr_pkg::DATA_W-1:0] old_val;
    logic [amr_pkg::DATA_W-1:0] opnd;

    always_comb
    begin
        for (int i = 0; i < amr_pkg::LANES; i++)
        begin
            old_raw[8*i +: 8] = bank_rd[req_addr_reg[2:0] + amr_pkg::LANE_W'(i)];
        end
    end

    assign mask    = amr_pkg::size_mask(req_cnt_reg);
    // Powered off: every load sees zero.
    assign old_val = power_on_reg ? (old_raw & mask) : '0;
    assign opnd    = req_wdata_reg & mask;

    // Reservations follow LR/SC even while powered off.
    amr_pkg::resv_req_t resv_req;
    logic               sc_ok;

    assign resv_req.lr   = (req_mode_reg == amr_pkg::OP_LR);
    assign resv_req.sc   = (req_mode_reg == amr_pkg::OP_SC);
    assign resv_req.who  = req_who_reg;
    assign resv_req.addr = req_addr_reg;
    assign resv_req.cnt  = req_cnt_reg;

    amr_resv #(
        .NUM_INITIATORS (NUM_INITIATORS)
    ) u_resv (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (exec_fire && req_ok),
        .req   (resv_req),
        .sc_ok (sc_ok)
    );

    amr_alu u_alu (
        .mode     (req_mode_reg),
        .cnt      (req_cnt_reg),
        .old_val  (old_val),
        .opnd     (opnd),
        .sc_ok    (sc_ok),
        .new_val  (new_val),
        .ret_val  (ret_val),
        .do_write (do_write)
    );

    // Drop writes while powered off or for rejected accesses.
    assign wr_en = exec_fire && req_ok && do_write && power_on_reg;

    always_comb
    begin
        state_next      = state_reg;
        power_on_next   = cfg_wr_en ? cfg_wr_data : power_on_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        req_mode_next   = req_mode_reg;
        req_addr_next   = req_addr_reg;
        req_cnt_next    = req_cnt_reg;
        req_wdata_next  = req_wdata_reg;
        req_who_next    = req_who_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Hold the request while the lane reads are in flight.
                if (accept)
                begin
                    req_mode_next  = in_mode;
                    req_addr_next  = in_addr;
                    req_cnt_next   = in_cnt;
                    req_wdata_next = in_wdata;
                    req_who_next   = in_who;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Write back and load the result once the output slot frees.
                if (exec_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = !req_ok;
                    out_data_next   = req_ok ? ret_val : '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            power_on_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            power_on_reg  <= power_on_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        req_mode_reg   <= req_mode_next;
        req_addr_reg   <= req_addr_next;
        req_cnt_reg    <= req_cnt_next;
        req_wdata_reg  <= req_wdata_next;
        req_who_reg    <= req_who_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

### hdl/amr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_checker
// Port-level properties of the atomic memory, bound to the top level.
// ----------------------------------------------------------------------------
`include "atomic_memory_with_reservations_defines.svh"

module amr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result word holds.
    `AMR_CHECK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // An invalid access returns zero data.
    `AMR_CHECK_NOW(a_invalid_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 64'd0)

    // The cycle after an accept is spent on write-back.
    `AMR_CHECK_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // With an empty output at the accept, the result shows right after the execute state.
    `AMR_CHECK_NOW(a_result_latency, $past(rst_n, 2) && $past(rst_n, 1) && $past(s_axis_tvalid && s_axis_tready, 2) && !$past(m_axis_tvalid, 2), m_axis_tvalid)

endmodule

bind atomic_memory_with_reservations amr_checker u_amr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### dv/atomic_memory_with_reservations_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atomic_memory_with_reservations_tb
// Self-checking bench for the atomic memory: drives access words, predicts
// every result word in a scoreboard and compares status and read data.
// ----------------------------------------------------------------------------
// The bench runs a short directed list first: extremes of address, byte count
// and operand, every opcode, unused opcodes, and the LR/SC corner cases.
// Random traffic follows. Most of it hits a small window so that atomics and
// reservations from different initiators collide. The power register is set
// on, off and back on between phases, only while no access is in flight.
// Never-written bytes are never read: such an access is turned into a write.
// ----------------------------------------------------------------------------
module atomic_memory_with_reservations_tb;
    import amr_pkg::*;

    localparam int STORE_BYTES   = MEM_BYTES_DEF;
    localparam int NUM_INIT      = NUM_INIT_DEF;
    localparam int WIN_LO        = 16'h0040;   // contended window, pre-filled
    localparam int WIN_BYTES     = 64;
    localparam int TOP_LO        = 16'hFFF0;   // last 16 bytes, pre-filled
    localparam int HOLD_CYCLES   = 300;        // one long receiver hold-off
    localparam int SETTLE_CYCLES = 6;          // block latency plus margin
    localparam int WATCHDOG      = 5000;       // cycles with no word moving

    localparam logic       ST_OK          = 1'b0;
    localparam logic       ST_BAD         = 1'b1;
    localparam logic [3:0] MODE_UNUSED_LO = OP_MAXU + 4'd1;
    localparam logic [3:0] MODE_UNUSED_HI = '1;

    typedef struct packed {
        logic        status;
        logic [63:0] read_data;
    } amo_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the byte store, the reservation table and the
    // power bit; predicts one result word per accepted access word.
    // ------------------------------------------------------------------------
    class amo_scoreboard;
        bit [7:0]    mem [STORE_BYTES];
        bit          resv_valid [NUM_INIT];
        bit [15:0]   resv_addr [NUM_INIT];
        bit          powered;
        amo_result_t result_q[$];
        int          errors;
        int          accesses;
        int          rejected;
        int          sc_pass;
        int          sc_fail;
        int          checked;

        function new();
            powered = 1'b1;
        endfunction

        function bit [63:0] byte_mask(int n);
            if (n >= 8)
                return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        function bit [63:0] widen_signed(bit [63:0] v, int n);
            logic signed [63:0] t;
            int sh;
            if (n >= 8)
                return v;
            sh = 64 - 8 * n;
            t = v << sh;
            return t >>> sh;
        endfunction

        function bit [63:0] fetch(bit [15:0] addr, int n);
            bit [63:0] v;
            v = '0;
            for (int i = 0; i < n; i++)
                v[8*i +: 8] = mem[int'(addr) + i];
            return v;
        endfunction

        function void store(bit [15:0] addr, int n, bit [63:0] v);
            if (!powered)
                return;
            for (int i = 0; i < n; i++)
                mem[int'(addr) + i] = v[8*i +: 8];
        endfunction

        function void note_access(bit [3:0] mode, bit [15:0] addr, bit [3:0] cnt,
                                  bit [63:0] wdata, bit [3:0] who);
            amo_result_t r;
            bit [63:0]   m;
            bit [63:0]   old;
            bit [63:0]   opnd;
            bit [63:0]   upd;
            bit          commit;
            int          n;
            n = int'(cnt);
            accesses++;
            r.status = ST_BAD;
            r.read_data = '0;
            if (n < 1 || n > 8 || mode > OP_MAXU || int'(addr) + n > STORE_BYTES)
            begin
                rejected++;
                result_q.push_back(r);
                return;
            end
            r.status = ST_OK;
            m = byte_mask(n);
            opnd = wdata & m;
            if (mode == OP_WRITE)
            begin
                store(addr, n, opnd);
                result_q.push_back(r);
                return;
            end
            old = powered ? fetch(addr, n) : 64'd0;
            commit = 1'b1;
            upd = '0;
            case (mode)
                OP_READ:
                    commit = 1'b0;
                OP_LR:
                begin
                    resv_valid[who] = 1'b1;
                    resv_addr[who] = addr;
                    commit = 1'b0;
                end
                OP_SC:
                begin
                    if (resv_valid[who] && resv_addr[who] == addr)
                    begin
                        // drop every reservation that falls inside the stored bytes
                        for (int k = 0; k < NUM_INIT; k++)
                            if (resv_valid[k] && int'(resv_addr[k]) >= int'(addr) &&
                                int'(resv_addr[k]) < int'(addr) + n)
                                resv_valid[k] = 1'b0;
                        upd = opnd;
                        old = 64'd0;
                        sc_pass++;
                    end
                    else
                    begin
                        commit = 1'b0;
                        old = 64'd1;
                        sc_fail++;
                    end
                end
                OP_SWAP: upd = opnd;
                OP_ADD:  upd = old + opnd;
                OP_XOR:  upd = old ^ opnd;
                OP_AND:  upd = old & opnd;
                OP_OR:   upd = old | opnd;
                OP_MIN:
                    upd = ($signed(widen_signed(old, n)) < $signed(widen_signed(opnd, n)))
                          ? old : opnd;
                OP_MAX:
                    upd = ($signed(widen_signed(old, n)) > $signed(widen_signed(opnd, n)))
                          ? old : opnd;
                OP_MINU: upd = (old < opnd) ? old : opnd;
                default: upd = (old > opnd) ? old : opnd;
            endcase
            r.read_data = old & m;
            if (commit)
                store(addr, n, upd & m);
            result_q.push_back(r);
        endfunction

        function void check_result(logic status, logic [63:0] data);
            amo_result_t exp_r;
            if (result_q.size() == 0)
            begin
                $error("result word with no access outstanding: status %0b, read_data %h",
                       status, data);
                errors++;
                return;
            end
            exp_r = result_q.pop_front();
            checked++;
            if (status !== exp_r.status)
            begin
                $error("status mismatch: expected %0b, actual %0b", exp_r.status, status);
                errors++;
            end
            if (data !== exp_r.read_data)
            begin
                $error("read_data mismatch: expected %h, actual %h", exp_r.read_data, data);
                errors++;
            end
        endfunction

        function int outstanding();
            return result_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [15:0] address, [19:16] byte_count, [83:20] write_data, [87:84] initiator
    logic [87:0] s_axis_tdata;
    // [3:0] mode
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [63:0] read_data
    logic [63:0] m_axis_tdata;
    // [0] status
    logic [0:0]  m_axis_tuser;
    logic        cfg_wr_en;
    logic        cfg_wr_data;

    amo_scoreboard sb;
    bit            written_map [STORE_BYTES];  // bytes that hold a defined value
    int            sent;
    bit            steady;                  // both sides run without gaps
    bit            hold_req;                // ask the receiver for a long hold-off
    int            quiet_cycles;

    atomic_memory_with_reservations uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: note accepted access words, check accepted result words, and
    // end the run if no word moves for too long. Sample at the edge, so the
    // values seen are the ones the block saw.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_access(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[19:16],
                               s_axis_tdata[83:20], s_axis_tdata[87:84]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser[0], m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                         WATCHDOG, sb.outstanding());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall at random before each result word (not while steady); once,
    // hold off for a long stretch so the block fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = steady ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk iff m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Offer one access word after a random gap and wait for it to be taken.
    // An in-range access that would read a never-written byte becomes a write.
    task automatic send_access(logic [3:0] mode, logic [15:0] addr, logic [3:0] cnt,
                               logic [63:0] wdata, logic [3:0] who);
        int gap;
        int n;
        bit fits;
        n = int'(cnt);
        fits = (n >= 1 && n <= 8 && mode <= OP_MAXU && int'(addr) + n <= STORE_BYTES);
        if (fits && mode != OP_WRITE)
            for (int i = 0; i < n; i++)
                if (!written_map[int'(addr) + i])
                    mode = OP_WRITE;
        if (fits && mode == OP_WRITE && sb.powered)
            for (int i = 0; i < n; i++)
                written_map[int'(addr) + i] = 1'b1;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {who, wdata, cnt, addr};
        s_axis_tuser  <= mode;
        @(posedge clk iff s_axis_tready);
        sent++;
        // switch between gappy and back-to-back stretches now and then
        if (sent % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
    endtask

    // Operand with a bias toward sign boundaries and all-zero / all-one values.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 64'h0;
            1:       return '1;
            2:       return 64'h8080_8080_8080_8080;
            3:       return 64'h7F7F_7F7F_7F7F_7F7F;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic window_access();
        int n;
        n = $urandom_range(1, 8);
        send_access(4'($urandom_range(0, OP_MAXU)),
                    16'(WIN_LO + $urandom_range(0, WIN_BYTES - n)),
                    4'(n), pick_operand(), 4'($urandom_range(0, NUM_INIT - 1)));
    endtask

    // LR, a few accesses (some from rival initiators at the same address),
    // then SC from the same initiator, usually at the reserved address.
    task automatic reservation_run();
        int owner;
        int rival;
        int base;
        int steps;
        owner = $urandom_range(0, NUM_INIT - 1);
        base  = WIN_LO + $urandom_range(0, WIN_BYTES - 9);
        steps = $urandom_range(0, 3);
        send_access(OP_LR, 16'(base), 4'($urandom_range(1, 8)), pick_operand(), 4'(owner));
        repeat (steps)
        begin
            rival = $urandom_range(0, NUM_INIT - 1);
            case ($urandom_range(0, 5))
                0: send_access(OP_LR, 16'(base), 4'($urandom_range(1, 8)), pick_operand(),
                               4'(rival));
                1: send_access(OP_SC, 16'(base - $urandom_range(0, 3)),
                               4'($urandom_range(1, 8)), pick_operand(), 4'(rival));
                default: window_access();
            endcase
        end
        send_access(OP_SC, 16'(($urandom_range(0, 4) == 0) ? base + 1 : base),
                    4'($urandom_range(1, 8)), pick_operand(), 4'(owner));
    endtask

    task automatic random_phase(int count);
        int stop;
        int pick;
        stop = sent + count;
        while (sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                reservation_run();
            else if (pick < 75)
                window_access();
            else if (pick < 83)
                send_access(OP_WRITE, 16'($urandom_range(0, 16'hFFFF)),
                            4'($urandom_range(1, 8)), {$urandom, $urandom},
                            4'($urandom_range(0, NUM_INIT - 1)));
            else if (pick < 88)
                send_access(4'($urandom_range(0, OP_MAXU)), 16'($urandom_range(0, 16'hFFFF)),
                            4'($urandom_range(1, 8)), pick_operand(),
                            4'($urandom_range(0, NUM_INIT - 1)));
            else if (pick < 94)
                // near the top: some run past the end
                send_access(4'($urandom_range(0, OP_MAXU)),
                            16'(TOP_LO + $urandom_range(0, 15)),
                            4'($urandom_range(1, 8)), pick_operand(),
                            4'($urandom_range(0, NUM_INIT - 1)));
            else
                send_access(4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
                            4'($urandom_range(0, 15)), {$urandom, $urandom},
                            4'($urandom_range(0, NUM_INIT - 1)));
        end
    endtask

    // Drop valid, then wait until every result is back and the pipe is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_power(bit on);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge clk);
        sb.powered = on;
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic directed_accesses();
        send_access(OP_WRITE, 16'h0040, 4'd8, 64'h8877_6655_4433_2211, 4'd0);
        send_access(OP_WRITE, 16'h0048, 4'd8, 64'hF0E1_D2C3_B4A5_9687, 4'd0);
        // lowest and highest addresses
        send_access(OP_WRITE, 16'h0000, 4'd8, '1, 4'd1);
        send_access(OP_WRITE, 16'hFFF8, 4'd8, 64'h0123_4567_89AB_CDEF, 4'd2);
        send_access(OP_READ,  16'hFFF8, 4'd8, '0, 4'd2);
        // one byte past the end, bad byte counts, unused opcodes
        send_access(OP_READ,  16'hFFFF, 4'd2, '0, 4'd2);
        send_access(OP_READ,  16'h0040, 4'd0, '0, 4'd0);
        send_access(OP_WRITE, 16'h0040, 4'd9, '1, 4'd0);
        send_access(MODE_UNUSED_LO, 16'h0040, 4'd4, '1, 4'd0);
        send_access(MODE_UNUSED_HI, 16'h0040, 4'd15, '1, 4'd15);
        send_access(OP_READ,  16'h0041, 4'd7, '0, 4'd0);
        // SC without a reservation, SC at the wrong address, a successful SC
        // that also kills a rival reservation inside its range, then a retry
        send_access(OP_LR, 16'h0040, 4'd8, '0, 4'd0);
        send_access(OP_LR, 16'h0044, 4'd4, '0, 4'd15);
        send_access(OP_SC, 16'h0040, 4'd4, 64'hAAAA_AAAA, 4'd1);
        send_access(OP_SC, 16'h0042, 4'd4, 64'hBBBB_BBBB, 4'd15);
        send_access(OP_SC, 16'h0040, 4'd8, 64'h1122_3344_5566_7788, 4'd0);
        send_access(OP_SC, 16'h0044, 4'd4, 64'hCCCC_CCCC, 4'd15);
        // every AMO; upper operand bytes must be ignored
        send_access(OP_SWAP, 16'h0048, 4'd8, 64'h8000_0000_0000_0001, 4'd3);
        send_access(OP_ADD,  16'h0048, 4'd8, '1, 4'd4);
        send_access(OP_XOR,  16'h0044, 4'd2, 64'hFFFF_FFFF_FFFF_A5A5, 4'd5);
        send_access(OP_AND,  16'h0042, 4'd3, 64'h0F0F_0F0F_0F0F_0F0F, 4'd6);
        send_access(OP_OR,   16'h004A, 4'd5, 64'h0000_0080_0000_0001, 4'd7);
        send_access(OP_MIN,  16'h0040, 4'd1, 64'h80, 4'd8);
        send_access(OP_MAX,  16'h0041, 4'd2, 64'h7FFF, 4'd9);
        send_access(OP_MINU, 16'h004C, 4'd4, '1, 4'd10);
        send_access(OP_MAXU, 16'h0043, 4'd6, 64'hFFFF_0000_0000_0000, 4'd11);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        sent = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_power(1'b1);
        directed_accesses();
        settle();

        // fill the contended window and the top bytes, then run powered
        for (int a = WIN_LO; a < WIN_LO + WIN_BYTES; a += 8)
            send_access(OP_WRITE, 16'(a), 4'd8, {$urandom, $urandom},
                        4'($urandom_range(0, 15)));
        send_access(OP_WRITE, 16'(TOP_LO), 4'd8, {$urandom, $urandom}, 4'd0);
        send_access(OP_WRITE, 16'(TOP_LO + 8), 4'd8, {$urandom, $urandom}, 4'd0);
        random_phase(200);
        hold_req = 1'b1;
        random_phase(200);
        settle();

        // powered off: data reads zero, writes dropped, reservations still live
        set_power(1'b0);
        random_phase(150);
        settle();

        set_power(1'b1);
        random_phase(450);
        settle();

        $display("Summary: %0d accesses, %0d results checked, %0d rejected as invalid",
                 sb.accesses, sb.checked, sb.rejected);
        $display("Summary: %0d SC passed, %0d SC failed, power cycled on/off/on",
                 sb.sc_pass, sb.sc_fail);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/amr_pkg.sv
hdl/amr_ram.sv
hdl/amr_resv.sv
hdl/amr_alu.sv
hdl/atomic_memory_with_reservations.sv
hdl/amr_checker.sv
dv/atomic_memory_with_reservations_tb.sv
